// ===== rtl/arpc_pkg.sv =====
package arpc_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int IFACE_W = 2;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int ACT_W   = 2;

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(300000);

  // operation kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // insert_action codes
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REFRESH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FILL    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EVICT   = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [IFACE_W-1:0] iface;
    logic [IP_W-1:0]    ip_addr;
    logic [MAC_W-1:0]   mac_addr;
    logic [TIME_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [MAC_W-1:0]   mac_out;
    logic               expired;
    logic [ACT_W-1:0]   insert_action;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   insert_count;
    logic [CNT_W-1:0]   eviction_count;
  } rsp_t;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [TIME_W-1:0]  expiry;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the request, restart the scan accumulators
    logic rd;      // read the table at the scan address
    logic commit;  // apply the decision, update counters, emit the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/arpc_in_if.sv =====
interface arpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [arpc_pkg::IFACE_W-1:0]  iface;
  logic [arpc_pkg::IP_W-1:0]     ip_addr;
  logic [arpc_pkg::MAC_W-1:0]    mac_addr;
  logic [arpc_pkg::TIME_W-1:0]   now;

  modport source (output valid, kind, iface, ip_addr, mac_addr, now, input ready);
  modport sink   (input valid, kind, iface, ip_addr, mac_addr, now, output ready);
endinterface

// ===== rtl/arpc_out_if.sv =====
interface arpc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [arpc_pkg::MAC_W-1:0]    mac_out;
  logic                          expired;
  logic [arpc_pkg::ACT_W-1:0]    insert_action;
  logic [arpc_pkg::CNT_W-1:0]    hit_count;
  logic [arpc_pkg::CNT_W-1:0]    miss_count;
  logic [arpc_pkg::CNT_W-1:0]    insert_count;
  logic [arpc_pkg::CNT_W-1:0]    eviction_count;

  modport source (output valid, found, mac_out, expired, insert_action, hit_count,
                  miss_count, insert_count, eviction_count, input ready);
  modport sink   (input valid, found, mac_out, expired, insert_action, hit_count,
                  miss_count, insert_count, eviction_count, output ready);
endinterface

// ===== rtl/arpc_ctrl.sv =====
module arpc_ctrl #(
  parameter int ENTRIES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  arpc_pkg::sts_t             sts,
  output arpc_pkg::cmd_t             cmd,
  output logic [$clog2(ENTRIES)-1:0] rd_addr
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    rd_addr   = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // last read word is folded into the accumulators this cycle
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/arpc_dp.sv =====
module arpc_dp #(
  parameter int ENTRIES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arpc_pkg::cmd_t             cmd,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output arpc_pkg::sts_t             sts,
  input  arpc_pkg::req_t             req,
  input  logic                       cfg_we,
  input  logic [arpc_pkg::TIME_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output arpc_pkg::rsp_t             rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  // table: one word per entry, plus an in-use bit per entry (set on insert, cleared on an expired lookup)
  arpc_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] used_r, used_nxt;

  logic [arpc_pkg::TIME_W-1:0] ttl_r;
  arpc_pkg::req_t              req_r;

  arpc_pkg::entry_t rd_data_r;
  logic             rd_used_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic                        match_hit_r, match_hit_nxt;
  logic [IDX_W-1:0]            match_idx_r, match_idx_nxt;
  logic [arpc_pkg::TIME_W-1:0] match_exp_r, match_exp_nxt;
  logic [arpc_pkg::MAC_W-1:0]  match_mac_r, match_mac_nxt;
  logic                        free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]            min_idx_r, min_idx_nxt;
  logic [arpc_pkg::TIME_W-1:0] min_exp_r, min_exp_nxt;

  logic [arpc_pkg::CNT_W-1:0]  hits_r, hits_nxt;
  logic [arpc_pkg::CNT_W-1:0]  misses_r, misses_nxt;
  logic [arpc_pkg::CNT_W-1:0]  inserts_r, inserts_nxt;
  logic [arpc_pkg::CNT_W-1:0]  evicts_r, evicts_nxt;

  logic                        out_valid_r;
  arpc_pkg::rsp_t              rsp_r, rsp_nxt;

  logic                        ent_busy;
  logic                        ent_match;
  logic [arpc_pkg::TIME_W:0]   exp_sum;
  logic [arpc_pkg::TIME_W-1:0] new_exp;
  logic                        mem_we;
  logic [IDX_W-1:0]            wr_idx;
  arpc_pkg::entry_t            wr_data;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign rsp          = rsp_r;

  // scan: fold one table word per cycle into the three searches
  always_comb begin
    ent_busy  = rd_used_r && (rd_data_r.expiry != '0);
    ent_match = ent_busy && (rd_data_r.iface == req_r.iface) && (rd_data_r.ip == req_r.ip_addr);

    match_hit_nxt = match_hit_r;
    match_idx_nxt = match_idx_r;
    match_exp_nxt = match_exp_r;
    match_mac_nxt = match_mac_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    min_idx_nxt   = min_idx_r;
    min_exp_nxt   = min_exp_r;

    if (cmd.load) begin
      match_hit_nxt = 1'b0;
      free_hit_nxt  = 1'b0;
    end else if (rd_vld_r) begin
      if (ent_match && !match_hit_r) begin
        match_hit_nxt = 1'b1;
        match_idx_nxt = rd_idx_r;
        match_exp_nxt = rd_data_r.expiry;
        match_mac_nxt = rd_data_r.mac;
      end
      if (!ent_busy && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
      // strict compare keeps the lowest index on a tie
      if ((rd_idx_r == '0) || (rd_data_r.expiry < min_exp_r)) begin
        min_idx_nxt = rd_idx_r;
        min_exp_nxt = rd_data_r.expiry;
      end
    end
  end

  // commit: decide, write back, count, build the result
  always_comb begin
    exp_sum = {1'b0, req_r.now} + {1'b0, ttl_r};
    new_exp = exp_sum[arpc_pkg::TIME_W] ? '1 : exp_sum[arpc_pkg::TIME_W-1:0];

    used_nxt    = used_r;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    inserts_nxt = inserts_r;
    evicts_nxt  = evicts_r;
    mem_we      = 1'b0;
    wr_idx      = match_idx_r;
    wr_data.iface  = req_r.iface;
    wr_data.ip     = req_r.ip_addr;
    wr_data.mac    = req_r.mac_addr;
    wr_data.expiry = new_exp;
    rsp_nxt     = '0;

    if (cmd.commit) begin
      if (req_r.kind == arpc_pkg::KIND_LOOKUP) begin
        rsp_nxt.insert_action = arpc_pkg::ACT_LOOKUP;
        if (!match_hit_r) begin
          misses_nxt = misses_r + 1'b1;
        end else if (req_r.now >= match_exp_r) begin
          used_nxt[match_idx_r] = 1'b0;
          rsp_nxt.expired       = 1'b1;
          misses_nxt            = misses_r + 1'b1;
        end else begin
          rsp_nxt.found   = 1'b1;
          rsp_nxt.mac_out = match_mac_r;
          hits_nxt        = hits_r + 1'b1;
        end
      end else begin
        mem_we      = 1'b1;
        inserts_nxt = inserts_r + 1'b1;
        if (match_hit_r) begin
          wr_idx                = match_idx_r;
          rsp_nxt.insert_action = arpc_pkg::ACT_REFRESH;
        end else if (free_hit_r) begin
          wr_idx                = free_idx_r;
          rsp_nxt.insert_action = arpc_pkg::ACT_FILL;
        end else begin
          wr_idx                = min_idx_r;
          rsp_nxt.insert_action = arpc_pkg::ACT_EVICT;
          evicts_nxt            = evicts_r + 1'b1;
        end
        used_nxt[wr_idx] = 1'b1;
      end
    end

    rsp_nxt.hit_count      = hits_nxt;
    rsp_nxt.miss_count     = misses_nxt;
    rsp_nxt.insert_count   = inserts_nxt;
    rsp_nxt.eviction_count = evicts_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
      rd_used_r <= used_r[rd_addr];
    end
    rd_idx_r <= rd_addr;
    if (cmd.load) begin
      req_r <= req;
    end
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
    end
    match_idx_r <= match_idx_nxt;
    match_exp_r <= match_exp_nxt;
    match_mac_r <= match_mac_nxt;
    free_idx_r  <= free_idx_nxt;
    min_idx_r   <= min_idx_nxt;
    min_exp_r   <= min_exp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ttl_r       <= arpc_pkg::TTL_RESET;
      rd_vld_r    <= 1'b0;
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      inserts_r   <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      rd_vld_r    <= cmd.rd;
      match_hit_r <= match_hit_nxt;
      free_hit_r  <= free_hit_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      inserts_r   <= inserts_nxt;
      evicts_r    <= evicts_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/arp_cache_with_expiry.sv =====
// Address-resolution cache with per-entry expiry.
// in_ch carries one operation per transaction: a lookup (kind 0) or an
// insert/refresh (kind 1) with interface, IPv4 address, MAC and current tick.
// out_ch returns exactly one result transaction per operation: hit/expired
// flags, the MAC on a hit, the insert action and the four running counters.
// cfg_we/cfg_wdata set the lifetime in ticks; write it only while idle.
// Timing: each operation scans the table one entry per cycle through a single
// read port, then takes a last fold step and a commit step before its result
// is valid. One operation is in flight at a time; in_ch.ready is high only
// while the scanner is idle, so the next operation is taken only after the
// previous one has committed. The result register frees the input from
// waiting on out_ch.ready.
// Reset (synchronous, rst_n low): all entries free, counters zero, lifetime
// 300000 ticks. Entry payloads are not cleared; an in-use bit per entry marks
// the occupied ones.
// Stall: if out_ch.ready stays low, the finished result holds in the output
// register and the next operation waits before its commit step.
module arp_cache_with_expiry #(
  parameter int ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arpc_in_if.sink                     in_ch,
  arpc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [arpc_pkg::TIME_W-1:0] cfg_wdata
);

  arpc_pkg::cmd_t             cmd;
  arpc_pkg::sts_t             sts;
  arpc_pkg::req_t             req;
  arpc_pkg::rsp_t             rsp;
  logic [$clog2(ENTRIES)-1:0] rd_addr;
  logic                       in_ready;
  logic                       out_valid;

  // pack the incoming transaction
  assign req.kind     = in_ch.kind;
  assign req.iface    = in_ch.iface;
  assign req.ip_addr  = in_ch.ip_addr;
  assign req.mac_addr = in_ch.mac_addr;
  assign req.now      = in_ch.now;
  assign in_ch.ready  = in_ready;

  // controller: sequences accept, table scan and commit
  arpc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // datapath: table memory, search accumulators, counters, output register
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .rsp       (rsp)
  );

  // drive the result transaction from the output register
  assign out_ch.valid          = out_valid;
  assign out_ch.found          = rsp.found;
  assign out_ch.mac_out        = rsp.mac_out;
  assign out_ch.expired        = rsp.expired;
  assign out_ch.insert_action  = rsp.insert_action;
  assign out_ch.hit_count      = rsp.hit_count;
  assign out_ch.miss_count     = rsp.miss_count;
  assign out_ch.insert_count   = rsp.insert_count;
  assign out_ch.eviction_count = rsp.eviction_count;

endmodule

// ===== verif/arp_cache_with_expiry_tb.sv =====
module arp_cache_with_expiry_tb;

  localparam int IP_W    = arpc_pkg::IP_W;
  localparam int MAC_W   = arpc_pkg::MAC_W;
  localparam int IFACE_W = arpc_pkg::IFACE_W;
  localparam int TIME_W  = arpc_pkg::TIME_W;
  localparam int CNT_W   = arpc_pkg::CNT_W;

  localparam int N_ENTRIES   = 32;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off to back up the input
  localparam int N_KEYS      = 40;    // more keys than entries, so evictions happen
  localparam int PHASE_OPS   = 255;

  // Predict the cache: keep a private copy of the table and the counters,
  // work out the result of every accepted operation and queue it in order.
  class arp_cache_scoreboard;
    logic [TIME_W-1:0]  ttl_ticks;
    logic [TIME_W-1:0]  expiry_tab [N_ENTRIES];
    logic [IP_W-1:0]    ip_tab     [N_ENTRIES];
    logic [MAC_W-1:0]   mac_tab    [N_ENTRIES];
    logic [IFACE_W-1:0] iface_tab  [N_ENTRIES];
    logic [CNT_W-1:0]   hit_total, miss_total, insert_total, evict_total;
    arpc_pkg::rsp_t     awaited_q [$];
    int                 failures;
    int                 results_seen;

    function new();
      ttl_ticks = arpc_pkg::TTL_RESET;
      for (int i = 0; i < N_ENTRIES; i++) begin
        expiry_tab[i] = '0;
        ip_tab[i]     = '0;
        mac_tab[i]    = '0;
        iface_tab[i]  = '0;
      end
      hit_total    = '0;
      miss_total   = '0;
      insert_total = '0;
      evict_total  = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: result %0d: %s", results_seen, msg);
    endfunction

    function void note_operation(arpc_pkg::req_t op);
      arpc_pkg::rsp_t res;
      int             slot;
      logic [32:0]    sum;
      res  = '0;
      slot = -1;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (slot < 0 && expiry_tab[i] != '0 && iface_tab[i] == op.iface &&
            ip_tab[i] == op.ip_addr)
          slot = i;
      end
      if (op.kind == arpc_pkg::KIND_LOOKUP) begin
        res.insert_action = arpc_pkg::ACT_LOOKUP;
        if (slot < 0) begin
          miss_total++;
        end else if (op.now >= expiry_tab[slot]) begin
          expiry_tab[slot] = '0;
          res.expired = 1'b1;
          miss_total++;
        end else begin
          res.found   = 1'b1;
          res.mac_out = mac_tab[slot];
          hit_total++;
        end
      end else begin
        if (slot >= 0) begin
          res.insert_action = arpc_pkg::ACT_REFRESH;
        end else begin
          for (int i = 0; i < N_ENTRIES; i++)
            if (slot < 0 && expiry_tab[i] == '0) slot = i;
          if (slot >= 0) begin
            res.insert_action = arpc_pkg::ACT_FILL;
          end else begin
            // victim: earliest expiry, strict compare keeps the lowest index on ties
            slot = 0;
            for (int i = 1; i < N_ENTRIES; i++)
              if (expiry_tab[i] < expiry_tab[slot]) slot = i;
            res.insert_action = arpc_pkg::ACT_EVICT;
            evict_total++;
          end
          ip_tab[slot]    = op.ip_addr;
          iface_tab[slot] = op.iface;
        end
        mac_tab[slot] = op.mac_addr;
        sum = {1'b0, op.now} + {1'b0, ttl_ticks};
        expiry_tab[slot] = sum[32] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        insert_total++;
      end
      res.hit_count      = hit_total;
      res.miss_count     = miss_total;
      res.insert_count   = insert_total;
      res.eviction_count = evict_total;
      awaited_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
        note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endfunction

    function void check_result(arpc_pkg::rsp_t got);
      arpc_pkg::rsp_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
        note_failure("result transaction with no operation outstanding");
        return;
      end
      want = awaited_q.pop_front();
      compare_field("found",          64'(want.found),          64'(got.found));
      compare_field("mac_out",        64'(want.mac_out),        64'(got.mac_out));
      compare_field("expired",        64'(want.expired),        64'(got.expired));
      compare_field("insert_action",  64'(want.insert_action),  64'(got.insert_action));
      compare_field("hit_count",      64'(want.hit_count),      64'(got.hit_count));
      compare_field("miss_count",     64'(want.miss_count),     64'(got.miss_count));
      compare_field("insert_count",   64'(want.insert_count),   64'(got.insert_count));
      compare_field("eviction_count", 64'(want.eviction_count), 64'(got.eviction_count));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  arpc_in_if  in_ch ();
  arpc_out_if out_ch ();

  arp_cache_with_expiry #(
    .ENTRIES(N_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  arp_cache_scoreboard sb;
  int                  tx_calm = 0;
  int                  rx_calm = 0;
  int                  idle_cycles = 0;

  // Key pool for well-formed traffic: keys 20 to 31 reuse the IPs of keys 0 to
  // 11 on the inverted interface, so the interface compare matters.
  logic [IFACE_W-1:0]  key_iface [N_KEYS];
  logic [IP_W-1:0]     key_ip    [N_KEYS];

  // Draw a random per-transaction wait; now and then start a calm
  // stretch in which the side never idles.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 13);
  endfunction

  function automatic arpc_pkg::req_t make_op(logic kind, logic [IFACE_W-1:0] ifc,
                                             logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                             logic [TIME_W-1:0] now);
    arpc_pkg::req_t op;
    op.kind     = kind;
    op.iface    = ifc;
    op.ip_addr  = ip;
    op.mac_addr = mac;
    op.now      = now;
    return op;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  // Offer one operation after a random gap, hold it until the block takes
  // the transaction, then hand it to the predictor.
  task automatic send_op(input arpc_pkg::req_t op);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= op.kind;
    in_ch.iface    <= op.iface;
    in_ch.ip_addr  <= op.ip_addr;
    in_ch.mac_addr <= op.mac_addr;
    in_ch.now      <= op.now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_operation(op);
  endtask

  // Drop valid, let every outstanding result drain, then write the lifetime
  // while the block sits idle.
  task automatic set_ttl(input logic [TIME_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.ttl_ticks  = value;
  endtask

  // Accept results with random stalls; twice hold off for a long stretch so
  // the output register fills and the block stops taking input.
  task automatic drain_results();
    int             stall;
    int             n;
    arpc_pkg::rsp_t got;
    n = 0;
    forever begin
      stall = draw_gap(rx_calm);
      if (n == 60 || n == 1000) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.found          = out_ch.found;
      got.mac_out        = out_ch.mac_out;
      got.expired        = out_ch.expired;
      got.insert_action  = out_ch.insert_action;
      got.hit_count      = out_ch.hit_count;
      got.miss_count     = out_ch.miss_count;
      got.insert_count   = out_ch.insert_count;
      got.eviction_count = out_ch.eviction_count;
      sb.check_result(got);
      n++;
    end
  endtask

  // Refill the key pool with fresh random addresses, the middle keys copying the lowest ones.
  task automatic shuffle_keys();
    for (int k = 0; k < N_KEYS; k++) begin
      if (k < N_KEYS / 2 || k >= N_KEYS - 8) begin
        key_iface[k] = IFACE_W'($urandom_range(0, 3));
        key_ip[k]    = $urandom();
      end else begin
        key_iface[k] = ~key_iface[k - N_KEYS / 2];
        key_ip[k]    = key_ip[k - N_KEYS / 2];
      end
    end
  endtask

  // One random phase: mostly lookups and inserts on pooled keys at an
  // advancing tick, the rest fully random noise.
  task automatic run_phase(input logic [TIME_W-1:0] ttl, input int n_ops);
    logic [TIME_W-1:0] tick;
    int                step_max;
    int                k;
    logic              kind;
    arpc_pkg::req_t    op;
    set_ttl(ttl);
    shuffle_keys();
    tick = $urandom();
    if (ttl / 6 > 2000)   step_max = 2000;
    else if (ttl / 6 < 1) step_max = 1;
    else                  step_max = ttl / 6;
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        op = make_op(1'($urandom_range(0, 1)), IFACE_W'($urandom_range(0, 3)),
                     $urandom(), random_mac(), $urandom());
      end else begin
        k    = $urandom_range(0, N_KEYS - 1);
        kind = ($urandom_range(0, 99) < 45) ? arpc_pkg::KIND_INSERT : arpc_pkg::KIND_LOOKUP;
        tick = tick + $urandom_range(0, step_max);
        op   = make_op(kind, key_iface[k], key_ip[k], random_mac(), tick);
      end
      send_op(op);
    end
  endtask

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    // Hold every input at a known value from time zero.
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= arpc_pkg::KIND_LOOKUP;
    in_ch.iface    <= '0;
    in_ch.ip_addr  <= '0;
    in_ch.mac_addr <= '0;
    in_ch.now      <= '0;
    out_ch.ready   <= 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none
    @(posedge clk);

    // Directed part at the reset lifetime: empty-table miss, all-zero and
    // all-ones fields, the interface compare, expiry reached exactly,
    // refresh and saturation of the expiry.
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd0, 32'h0, 48'h0, 32'h0));
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd0, 32'h0, 48'h0, 32'h0));
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                    32'hFFFF_FFFF));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd3, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFE));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd1, 32'h0, 48'h0, 32'h0));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd0, 32'h0, 48'h0, 32'd299999));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd0, 32'h0, 48'h0, 32'd300000));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd0, 32'h0, 48'h0, 32'd300000));
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd2, 32'h0A00_0001, 48'h0200_0000_0001, 32'd10));
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd2, 32'h0A00_0001, 48'hAAAA_5555_AAAA, 32'd20));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd2, 32'h0A00_0001, 48'h0, 32'd21));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd3, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF));

    // Zero lifetime: an insert at tick zero stores an entry that reads free.
    set_ttl(32'd0);
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd1, 32'hC0A8_0001, 48'h0011_2233_4455, 32'd0));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd1, 32'hC0A8_0001, 48'h0, 32'd0));
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd1, 32'hC0A8_0001, 48'h0011_2233_4455, 32'd5));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd1, 32'hC0A8_0001, 48'h0, 32'd5));

    // Shortest and longest lifetimes.
    set_ttl(32'd1);
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd2, 32'h7F00_0001, random_mac(), 32'd100));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd2, 32'h7F00_0001, 48'h0, 32'd100));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd2, 32'h7F00_0001, 48'h0, 32'd101));
    set_ttl(32'hFFFF_FFFF);
    send_op(make_op(arpc_pkg::KIND_INSERT, 2'd3, 32'h1234_5678, random_mac(), 32'd7));
    send_op(make_op(arpc_pkg::KIND_LOOKUP, 2'd3, 32'h1234_5678, 48'h0, 32'hFFFF_FFFE));

    // Random phases over several lifetimes, extremes included.
    run_phase(arpc_pkg::TTL_RESET, PHASE_OPS);
    run_phase(32'd1, PHASE_OPS);
    run_phase(32'hFFFF_FFFF, PHASE_OPS);
    run_phase(TIME_W'($urandom_range(30, 300)), PHASE_OPS);
    run_phase(TIME_W'($urandom_range(1000, 5000)), PHASE_OPS);
    run_phase(TIME_W'($urandom_range(2, 65535)), PHASE_OPS);
    run_phase(32'd2, PHASE_OPS);

    // Drain, then give the block time to show any stray result.
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (N_ENTRIES + 8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/arpc_pkg.sv
rtl/arpc_in_if.sv
rtl/arpc_out_if.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_cache_with_expiry.sv
verif/arp_cache_with_expiry_tb.sv
